>>> design/mvm_pkg.sv
// Package with the shared constants and types of the matrix-vector multiplier.
`default_nettype none

package mvm_pkg;

	// Operation codes carried by an input request.
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_MATRIX = 1'b1;

	// Configuration register indexes.
	localparam int          CFG_IDX_W = 1;
	localparam logic [0:0]  REG_COLS  = 1'b0;
	localparam logic [0:0]  REG_ROWS  = 1'b1;

	// Register widths and reset values.
	localparam int          COLS_W      = 7;
	localparam int          ROWS_W      = 11;
	localparam int          CFG_DATA_W  = 11;
	localparam logic [6:0]  COLS_RESET  = 7'd32;
	localparam logic [10:0] ROWS_RESET  = 11'd25;

	// Payload widths.
	localparam int ELEM_W   = 16;
	localparam int PROD_W   = 32;
	localparam int SUM_W    = 40;
	localparam int ROW_IX_W = 10;

	// Matrix element on its way from the position logic to the MAC.
	typedef struct packed {
		logic                     valid;
		logic signed [ELEM_W-1:0] element_value;
		logic                     last_col;
		logic                     last_row;
		logic [ROW_IX_W-1:0]      row_index;
	} mvm_item_t;

endpackage

`default_nettype wire

>>> design/mvm_ifs.sv
// Handshake channel interfaces of the matrix-vector multiplier.
`default_nettype none

interface mvm_in_if;
	import mvm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic signed [ELEM_W-1:0] element_value;
	modport source (output valid, output operation, output element_value, input ready);
	modport sink   (input valid, input operation, input element_value, output ready);
endinterface

interface mvm_out_if;
	import mvm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [SUM_W-1:0]  row_sum;
	logic [ROW_IX_W-1:0]      row_index;
	logic                     last_row;
	modport source (output valid, output row_sum, output row_index, output last_row,
		input ready);
	modport sink   (input valid, input row_sum, input row_index, input last_row,
		output ready);
endinterface

interface mvm_cfg_if;
	import mvm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/mvm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module mvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire                                 clk,
	input  wire                                 we,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                     wdata,
	input  wire                                 re,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                    rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/mvm_ctrl.sv
// Configuration registers, load/column/row counters and vector memory addressing.
`default_nettype none

module mvm_ctrl #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 1024
) (
	input  wire                    clk,
	input  wire                    arst_n,
	mvm_cfg_if.sink                cfg,
	mvm_in_if.sink                 item,
	input  wire                    stall,
	output logic                   ram_we,
	output logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] ram_waddr,
	output logic [mvm_pkg::ELEM_W-1:0] ram_wdata,
	output logic                   ram_re,
	output logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] ram_raddr,
	output mvm_pkg::mvm_item_t     item_s1
);
	import mvm_pkg::*;

	localparam int CPW  = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
	localparam int CNW  = $clog2(MAX_COLS + 1);
	localparam int CXW  = (CNW > COLS_W ? CNW : COLS_W) + 1;
	localparam int RPW  = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
	localparam int RNW  = $clog2(MAX_ROWS + 1);
	localparam int RXW  = (RNW > ROWS_W ? RNW : ROWS_W) + 1;

	logic [COLS_W-1:0] cols_q;
	logic [ROWS_W-1:0] rows_q;
	logic [CPW-1:0]    load_pos_q;
	logic [CPW-1:0]    col_pos_q;
	logic [RPW-1:0]    row_pos_q;
	logic [CXW-1:0]    eff_cols;
	logic [RXW-1:0]    eff_rows;
	logic              accept;
	logic              is_load;
	logic              is_matrix;
	logic              load_last;
	logic              col_last;
	logic              row_last;

	// Configuration writes are taken at any time.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_COLS: cols_q <= cfg.data[COLS_W-1:0];
				REG_ROWS: rows_q <= cfg.data[ROWS_W-1:0];
			endcase
		end
	end

	// Clamp the register values to the range the memory and counters support.
	always_comb begin
		if (cols_q == '0) begin
			eff_cols = CXW'(1);
		end else if (CXW'(cols_q) > CXW'(MAX_COLS)) begin
			eff_cols = CXW'(MAX_COLS);
		end else begin
			eff_cols = CXW'(cols_q);
		end
		if (rows_q == '0) begin
			eff_rows = RXW'(1);
		end else if (RXW'(rows_q) > RXW'(MAX_ROWS)) begin
			eff_rows = RXW'(MAX_ROWS);
		end else begin
			eff_rows = RXW'(rows_q);
		end
	end

	// The whole pipeline holds when a row sum cannot be placed in the output.
	assign item.ready = !stall;
	assign accept     = item.valid && !stall;
	assign is_load    = accept && (item.operation == OP_LOAD);
	assign is_matrix  = accept && (item.operation == OP_MATRIX);

	assign load_last = (CXW'(load_pos_q) + CXW'(1)) >= eff_cols;
	assign col_last  = (CXW'(col_pos_q) + CXW'(1)) >= eff_cols;
	assign row_last  = (RXW'(row_pos_q) + RXW'(1)) >= eff_rows;

	// Vector loads write the memory; matrix elements read their column's entry.
	assign ram_we    = is_load;
	assign ram_waddr = load_pos_q;
	assign ram_wdata = item.element_value;
	assign ram_re    = is_matrix;
	assign ram_raddr = col_pos_q;

	// Position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			col_pos_q  <= '0;
			row_pos_q  <= '0;
		end else begin
			if (is_load) begin
				load_pos_q <= load_last ? '0 : load_pos_q + CPW'(1);
			end
			if (is_matrix) begin
				col_pos_q <= col_last ? '0 : col_pos_q + CPW'(1);
				if (col_last) begin
					row_pos_q <= row_last ? '0 : row_pos_q + RPW'(1);
				end
			end
		end
	end

	// Stage 1: element waits for the memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			if (!stall) begin
				item_s1.valid <= is_matrix;
			end
			if (is_matrix) begin
				item_s1.element_value <= item.element_value;
				item_s1.last_col      <= col_last;
				item_s1.last_row      <= row_last;
				item_s1.row_index     <= ROW_IX_W'(row_pos_q);
			end
		end
	end

endmodule

`default_nettype wire

>>> design/mvm_mac.sv
// Multiplier, row accumulator and output register of the matrix-vector multiplier.
`default_nettype none

module mvm_mac (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire mvm_pkg::mvm_item_t    item_s1,
	input  wire [mvm_pkg::ELEM_W-1:0]  vec_data,
	output logic                       stall,
	mvm_out_if.source                  result
);
	import mvm_pkg::*;

	logic                     valid_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     last_col_s2;
	logic                     last_row_s2;
	logic [ROW_IX_W-1:0]      row_index_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  sum;
	logic signed [ELEM_W-1:0] vec_elem;
	logic                     emit;

	assign vec_elem = signed'(vec_data);

	// A row end stalls only while the output register holds an untaken sum.
	assign stall = valid_s2 && last_col_s2 && result.valid && !result.ready;
	assign emit  = valid_s2 && last_col_s2 && !stall;

	// Stage 2: exact Q16.16 product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s2 <= item_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && item_s1.valid) begin
			prod_s2      <= PROD_W'(item_s1.element_value * vec_elem);
			last_col_s2  <= item_s1.last_col;
			last_row_s2  <= item_s1.last_row;
			row_index_s2 <= item_s1.row_index;
		end
	end

	// Row accumulator, cleared as each row sum leaves.
	assign sum = acc_q + SUM_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s2 && !stall) begin
			acc_q <= last_col_s2 ? '0 : sum;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (emit) begin
			result.valid <= 1'b1;
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result.row_sum   <= sum;
			result.row_index <= row_index_s2;
			result.last_row  <= last_row_s2;
		end
	end

`ifndef NO_ASSERTIONS
	// A stalled row end is still there in the next cycle.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> valid_s2 && last_col_s2)
		else $error("stalled row end was lost");

	// Only a row end can stall the pipeline.
	a_stall_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !last_col_s2) |-> !stall)
		else $error("mid-row element stalled");

	// The accumulator starts each row from zero.
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> acc_q == '0)
		else $error("accumulator not cleared after row sum");

	// A new row sum always lands in the output register.
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> result.valid)
		else $error("row sum not presented");
`endif

endmodule

`default_nettype wire

>>> design/matrix_vector_multiply.sv
// Top level of the streaming dense matrix-vector multiplier.
`default_nettype none

// Requests carry either a vector element (operation 0), written to the vector memory at the
// next load position, or a matrix element (operation 1) in row-major order, multiplied exactly
// by the stored vector element of its column and added to a 40-bit Q24.16 row accumulator.
// The block takes one request every cycle while not stalled. A row sum leaves once the last element
// of its row is taken, via memory read, multiply and accumulate into the output register; the input
// is held back only while a finished row sum meets an output register whose sum is not yet taken.
// The vector memory (MAX_COLS entries, one read and one write port) has no reset: every entry
// must be loaded before a matrix element reads it. Registers: index 0 is the column count, index
// 1 the row count; a count of zero acts as one and a count above the maximum as the maximum.
module matrix_vector_multiply #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 1024
) (
	input  wire       clk,
	input  wire       arst_n,
	mvm_cfg_if.sink   cfg,
	mvm_in_if.sink    item,
	mvm_out_if.source result
);
	import mvm_pkg::*;

	localparam int CPW = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;

	logic              ram_we;
	logic [CPW-1:0]    ram_waddr;
	logic [ELEM_W-1:0] ram_wdata;
	logic              ram_re;
	logic [CPW-1:0]    ram_raddr;
	logic [ELEM_W-1:0] ram_rdata;
	logic              stall;
	mvm_item_t         item_s1;

	// Counters and memory addressing.
	mvm_ctrl #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item      (item),
		.stall     (stall),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.item_s1   (item_s1)
	);

	// Vector store.
	mvm_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (MAX_COLS)
	) u_vec_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Multiply-accumulate and output.
	mvm_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_s1  (item_s1),
		.vec_data (ram_rdata),
		.stall    (stall),
		.result   (result)
	);

endmodule

`default_nettype wire
